/* design/bitmap_block_allocator_assert.svh */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_assert.svh
// assertion macros shared by the allocator modules
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

// next-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`else

`define BBA_ASSERT_IMP(label, ante, cons)
`define BBA_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* design/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// types and constants shared by the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int OFF_W   = 26;
    localparam int SIZE_W  = 16;
    localparam int INDEX_W = 10;
    localparam int FREE_W  = 11;
    localparam int WORD_W  = 64;

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_ALIGN  = 3'd3,
        ST_DOUBLE = 3'd4
    } status_t;

    typedef struct packed
    {
        op_t                operation;
        logic [OFF_W-1:0]   release_offset;
    } bba_req_t;

    typedef struct packed
    {
        status_t            status;
        logic [INDEX_W-1:0] block_index;
        logic [OFF_W-1:0]   byte_offset;
        logic [FREE_W-1:0]  free_count;
        logic               all_free;
    } bba_rsp_t;

    // controller to datapath
    typedef struct packed
    {
        logic    start;
        logic    rd_scan;
        logic    scan_adv;
        logic    find;
        logic    alloc_commit;
        logic    div_start;
        logic    rd_rel;
        logic    rel_commit;
        logic    load_out;
        status_t code;
    } bba_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic count_zero;
        logic out_of_range;
        logic div_done;
        logic misaligned;
        logic word_full;
        logic bit_set;
    } bba_sts_t;

endpackage

/* design/bba_div.sv */
// ----------------------------------------------------------------------------
// bba_div
// restoring divider, one quotient bit per cycle, offset by block size
// ----------------------------------------------------------------------------
module bba_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bba_pkg::OFF_W-1:0]   dividend,
    input  logic [bba_pkg::SIZE_W-1:0]  divisor,
    output logic                        done,
    output logic [bba_pkg::OFF_W-1:0]   quotient,
    output logic [bba_pkg::SIZE_W-1:0]  remainder
);
    import bba_pkg::*;

    localparam int CNT_W = $clog2(OFF_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [OFF_W-1:0]   dvd_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [SIZE_W-1:0]  dsr_reg;

    logic [SIZE_W:0]    trial;
    logic               ge;
    logic [SIZE_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[OFF_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(OFF_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[OFF_W-2:0], ge};
            rem_reg <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

/* design/bba_dp.sv */
// ----------------------------------------------------------------------------
// bba_dp
// allocator datapath: bitmap memory, scan pointer, free count, result register
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_assert.svh"

module bba_dp
#(
    parameter int WORDS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  bba_pkg::bba_req_t           req,
    input  bba_pkg::bba_cmd_t           cmd,
    output bba_pkg::bba_sts_t           sts,
    output bba_pkg::bba_rsp_t           rsp
);
    import bba_pkg::*;

    localparam int TOTAL  = WORDS * WORD_W;
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W  = WA_W + 6;
    localparam int PROD_W = (IDX_W + SIZE_W > OFF_W) ? IDX_W + SIZE_W : OFF_W;
    localparam int CMP_W  = (CNT_W + SIZE_W > OFF_W + 1) ? CNT_W + SIZE_W : OFF_W + 1;

    // count of leading ones, six halving steps
    function automatic logic [5:0] lead_ones(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] top_mask;
        logic [5:0]        pos;
        v   = w;
        pos = '0;
        for (int k = 5; k >= 0; k--)
        begin
            top_mask = ~({WORD_W{1'b1}} >> (1 << k));
            if ((v & top_mask) == top_mask)
            begin
                pos[k] = 1'b1;
                v      = v << (1 << k);
            end
        end
        return pos;
    endfunction

    logic [WORD_W-1:0]  bitmap_mem [WORDS];
    logic [WORDS-1:0]   word_valid_reg;
    logic               rd_valid_reg;
    logic [WORD_W-1:0]  rd_data_reg;

    logic [SIZE_W-1:0]  block_bytes_reg;
    logic [WA_W-1:0]    scan_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [CMP_W-1:0]   lim_reg;
    logic               all_free_reg;
    bba_rsp_t           rsp_reg;

    logic [SIZE_W-1:0]  size_eff;
    logic [WORD_W-1:0]  rd_word;
    logic [WORD_W-1:0]  bit_mask;
    logic               mem_re;
    logic               mem_we;
    logic [WA_W-1:0]    rd_addr;
    logic [WA_W-1:0]    wr_addr;
    logic [WORD_W-1:0]  wr_word;
    logic [PROD_W-1:0]  alloc_prod;
    logic               div_done;
    logic [OFF_W-1:0]   div_quot;
    logic [SIZE_W-1:0]  div_rem;
    logic               keep_fields;

    assign size_eff = (block_bytes_reg == '0) ? SIZE_W'(1) : block_bytes_reg;
    assign rd_word  = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask = {1'b1, {(WORD_W-1){1'b0}}} >> idx_reg[5:0];

    assign mem_re  = cmd.rd_scan | cmd.rd_rel;
    assign rd_addr = cmd.rd_scan ? scan_ptr_reg : div_quot[IDX_W-1:6];
    assign mem_we  = cmd.alloc_commit | cmd.rel_commit;
    assign wr_addr = idx_reg[IDX_W-1:6];
    assign wr_word = cmd.alloc_commit ? (rd_word | bit_mask) : (rd_word & ~bit_mask);

    assign alloc_prod = PROD_W'(idx_reg) * PROD_W'(size_eff);

    bba_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (off_reg),
        .divisor   (size_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // bitmap words, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[wr_addr] <= wr_word;
        end
        if (mem_re)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // a word never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_valid_reg <= word_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= SIZE_W'(1);
            scan_ptr_reg    <= '0;
            count_reg       <= CNT_W'(TOTAL);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                block_bytes_reg <= cfg_wr_data;
            end
            if (cmd.scan_adv)
            begin
                scan_ptr_reg <= (scan_ptr_reg == WA_W'(WORDS - 1)) ? '0
                              : scan_ptr_reg + WA_W'(1);
            end
            if (cmd.alloc_commit)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.rel_commit)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign keep_fields = (cmd.code == ST_OK) || (cmd.code == ST_DOUBLE);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            off_reg      <= req.release_offset;
            lim_reg      <= CMP_W'(TOTAL) * CMP_W'(size_eff);
            all_free_reg <= 1'b0;
        end
        if (cmd.find)
        begin
            idx_reg <= {scan_ptr_reg, lead_ones(rd_word)};
        end
        if (cmd.rd_rel)
        begin
            idx_reg <= div_quot[IDX_W-1:0];
        end
        if (cmd.alloc_commit)
        begin
            off_reg <= alloc_prod[OFF_W-1:0];
        end
        if (cmd.rel_commit)
        begin
            all_free_reg <= (count_reg == CNT_W'(TOTAL - 1));
        end
        if (cmd.load_out)
        begin
            rsp_reg.status      <= cmd.code;
            rsp_reg.block_index <= keep_fields ? INDEX_W'(idx_reg) : '0;
            rsp_reg.byte_offset <= keep_fields ? off_reg : '0;
            rsp_reg.free_count  <= FREE_W'(count_reg);
            rsp_reg.all_free    <= all_free_reg;
        end
    end

    assign sts.count_zero   = (count_reg == '0);
    assign sts.out_of_range = CMP_W'(off_reg) >= lim_reg;
    assign sts.div_done     = div_done;
    assign sts.misaligned   = (div_rem != '0);
    assign sts.word_full    = &rd_word;
    assign sts.bit_set      = |(rd_word & bit_mask);

    assign rsp = rsp_reg;

    `BBA_ASSERT_IMP(a_alloc_bit_clear, cmd.alloc_commit, (rd_word & bit_mask) == '0)
    `BBA_ASSERT_NXT(a_alloc_count, cmd.alloc_commit, count_reg == $past(count_reg) - CNT_W'(1))
    `BBA_ASSERT_NXT(a_rel_count, cmd.rel_commit, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

/* design/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// allocator controller: sequences scan, divide, bitmap update and hand-off
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_assert.svh"

module bba_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  bba_pkg::op_t        req_op,
    output logic                req_ready,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    input  bba_pkg::bba_sts_t   sts,
    output bba_pkg::bba_cmd_t   cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC,
        S_RANGE,
        S_DIV,
        S_REL_CHK,
        S_FINISH
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;
    logic    rsp_valid_reg;
    logic    rsp_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        code_next      = code_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (req_op == OP_ALLOC)
                    begin
                        if (sts.count_zero)
                        begin
                            code_next  = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_RANGE;
                    end
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.word_full)
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SCAN_RD;
                end
                else
                begin
                    cmd.find   = 1'b1;
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_commit = 1'b1;
                code_next        = ST_OK;
                state_next       = S_FINISH;
            end
            S_RANGE:
            begin
                if (sts.out_of_range)
                begin
                    code_next  = ST_RANGE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.misaligned)
                    begin
                        code_next  = ST_ALIGN;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.rd_rel = 1'b1;
                        state_next = S_REL_CHK;
                    end
                end
            end
            S_REL_CHK:
            begin
                if (sts.bit_set)
                begin
                    cmd.rel_commit = 1'b1;
                    code_next      = ST_OK;
                end
                else
                begin
                    code_next = ST_DOUBLE;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the output register to free up
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.code = code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `BBA_ASSERT_IMP(a_load_slot_free, cmd.load_out, !rsp_valid_reg || rsp_ready)
    `BBA_ASSERT_IMP(a_scan_not_full, state_reg == S_SCAN_RD, !sts.count_zero)
    `BBA_ASSERT_IMP(a_div_done_in_div, sts.div_done, state_reg == S_DIV)

endmodule

/* design/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// fixed-size block allocator over a next-fit bitmap of WORDS 64-bit words
//
// req channel (valid/ready) carries one beat per request: operation 0
// allocates one block, operation 1 releases the block at release_offset.
// rsp channel (valid/ready) returns one beat per request with status, block
// index, byte offset, remaining free count and the all-free flag.
// block size is written through cfg_wr_en/cfg_wr_data between requests.
// one request is in flight at a time; req_ready is high while idle.
// allocate: the controller reads and then checks one bitmap word at a time,
// k words in all (1 to WORDS), on the single bitmap read port, then commits
// the block and hands off; allocate when full goes straight to the hand-off.
// release: a range check, then the 26-step bit-serial divide of the offset
// by the block size, then, if aligned, one bitmap read and, if set, a write.
// reset empties the bitmap (per-word valid bits, no clearing pass), sets the
// free count to WORDS*64, the scan start to word 0 and the block size to 1.
// a stalled rsp beat holds in the output register; the next request is
// taken meanwhile and waits in its last step until that beat leaves.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
#(
    parameter int WORDS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bba_pkg::bba_req_t           req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output bba_pkg::bba_rsp_t           rsp
);
    import bba_pkg::*;

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.operation),
        .req_ready (req_ready),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    bba_dp
    #(
        .WORDS (WORDS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule
